/* sv/dsfe_pkg.sv */
package dsfe_pkg;

  localparam int FRAME_BYTES = 20;
  localparam int BYTE_IDX_W  = 5;
  localparam int QUEUE_DEPTH = 2;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_BLINK_PERIOD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLINK_ON     = 2'd1;
  localparam logic [3:0] BLINK_PERIOD_RST = 4'd10;
  localparam logic [3:0] BLINK_ON_RST     = 4'd5;

  localparam int FLAG_LEFT    = 0;
  localparam int FLAG_RIGHT   = 1;
  localparam int FLAG_HEAD    = 2;
  localparam int FLAG_CRUISE  = 3;
  localparam int FLAG_ECO     = 4;
  localparam int FLAG_REVERSE = 5;
  localparam int FLAG_BRAKE   = 6;
  localparam int FLAG_CHARGE  = 7;
  localparam int FLAG_PLAY    = 8;
  localparam int FLAG_CLOCK   = 9;
  localparam int FLAG_SETTING = 10;

  localparam logic [1:0] MEDIA_FM  = 2'd1;
  localparam logic [1:0] MEDIA_USB = 2'd2;
  localparam logic [1:0] MEDIA_BT  = 2'd3;

  localparam logic [2:0] MODE_ONE   = 3'd1;
  localparam logic [2:0] MODE_TWO   = 3'd2;
  localparam logic [2:0] MODE_THREE = 3'd3;
  localparam logic [2:0] MODE_FOUR  = 3'd4;

  localparam int STEP_W = 5;
  localparam logic [STEP_W-1:0] STEP_MILE  = 5'd0;
  localparam logic [STEP_W-1:0] STEP_TRACK = 5'd5;
  localparam logic [STEP_W-1:0] STEP_VOLT  = 5'd8;
  localparam logic [STEP_W-1:0] STEP_TEMP  = 5'd11;
  localparam logic [STEP_W-1:0] STEP_SPEED = 5'd14;
  localparam logic [STEP_W-1:0] STEP_HOUR  = 5'd16;
  localparam logic [STEP_W-1:0] STEP_MIN   = 5'd17;
  localparam logic [STEP_W-1:0] STEP_LAST  = 5'd17;

  localparam int DIG_SLOTS     = 20;
  localparam int DIG_MILE      = 0;
  localparam int DIG_TRACK     = 5;
  localparam int DIG_VOLT_TENS = 9;
  localparam int DIG_VOLT_HUND = 10;
  localparam int DIG_TEMP_ONES = 12;
  localparam int DIG_TEMP_TENS = 13;
  localparam int DIG_SPD_ONES  = 14;
  localparam int DIG_SPD_TENS  = 15;
  localparam int DIG_HOUR_ONES = 16;
  localparam int DIG_MIN_ONES  = 17;
  localparam int DIG_HOUR_TENS = 18;
  localparam int DIG_MIN_TENS  = 19;

  typedef struct packed {
    logic [10:0]                flags;
    logic [1:0]                 media;
    logic [3:0]                 bat;
    logic                       temp_neg;
    logic [2:0]                 edit;
    logic [2:0]                 mode;
    logic                       trk_big;
    logic                       on;
    logic [DIG_SLOTS-1:0][3:0]  dig;
  } dsfe_rec_t;

endpackage

/* sv/dashboard_segment_frame_encoder_top.sv */
// Dashboard segment frame encoder.
// Input channel: one status snapshot per beat, taken when push_i is high and
// full_o is low. Each snapshot yields a 20-byte segment LCD frame, one byte per
// result beat on the output channel: the oldest byte shows while empty_o is
// low and is taken when pop_i is high. frame_last_o marks byte 19.
// The front stage takes a snapshot, steps the blink counter and splits every
// number into decimal digits through one shared divide-by-ten unit, one digit
// per cycle, then hands the record to the queue. The back stage emits one byte
// per cycle while pop_i is high, so it sets the snapshot rate; the front stage
// takes no new snapshot until it hands its finished record to the queue.
// Configuration: cfg_ready_o is always high; index 0 is the blink period,
// index 1 the blink on limit; writes to other indexes are dropped.
// Reset: blink counter 0, period 10, on limit 5, queue and output empty.
// Output stall: the current byte holds, the record queue fills, then the front
// holds its finished record and full_o stays high until space frees up.
module dashboard_segment_frame_encoder_top #(
  parameter int QUEUE_DEPTH = dsfe_pkg::QUEUE_DEPTH
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           push_i,
  output logic                           full_o,
  input  logic [10:0]                    indicator_flags_i,
  input  logic [1:0]                     media_source_i,
  input  logic [3:0]                     battery_level_i,
  input  logic signed [10:0]             temperature_i,
  input  logic [6:0]                     clock_hour_i,
  input  logic [6:0]                     clock_minute_i,
  input  logic [2:0]                     edit_digit_i,
  input  logic [15:0]                    battery_voltage_i,
  input  logic [16:0]                    mileage_i,
  input  logic [7:0]                     road_speed_i,
  input  logic [2:0]                     drive_mode_i,
  input  logic [15:0]                    track_number_i,
  output logic                           empty_o,
  input  logic                           pop_i,
  output logic [4:0]                     byte_index_o,
  output logic [7:0]                     segment_byte_o,
  output logic                           frame_last_o,
  output logic                           left_lamp_o,
  output logic                           right_lamp_o,
  output logic                           headlight_lamp_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [dsfe_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [3:0]                     cfg_data_i
);
  import dsfe_pkg::*;

  logic [3:0] blink_period_q, blink_on_limit_q;
  dsfe_rec_t  front_rec, queue_rec;
  logic       rec_push, rec_full, rec_pop, rec_empty;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blink_period_q   <= BLINK_PERIOD_RST;
      blink_on_limit_q <= BLINK_ON_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_BLINK_PERIOD: blink_period_q   <= cfg_data_i;
        CFG_BLINK_ON:     blink_on_limit_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  dsfe_front u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .push_i            (push_i),
    .full_o            (full_o),
    .indicator_flags_i (indicator_flags_i),
    .media_source_i    (media_source_i),
    .battery_level_i   (battery_level_i),
    .temperature_i     (temperature_i),
    .clock_hour_i      (clock_hour_i),
    .clock_minute_i    (clock_minute_i),
    .edit_digit_i      (edit_digit_i),
    .battery_voltage_i (battery_voltage_i),
    .mileage_i         (mileage_i),
    .road_speed_i      (road_speed_i),
    .drive_mode_i      (drive_mode_i),
    .track_number_i    (track_number_i),
    .blink_period_i    (blink_period_q),
    .blink_on_limit_i  (blink_on_limit_q),
    .rec_o             (front_rec),
    .rec_push_o        (rec_push),
    .rec_full_i        (rec_full)
  );

  dsfe_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (rec_push),
    .rec_i   (front_rec),
    .full_o  (rec_full),
    .pop_i   (rec_pop),
    .rec_o   (queue_rec),
    .empty_o (rec_empty)
  );

  dsfe_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .rec_i            (queue_rec),
    .rec_empty_i      (rec_empty),
    .rec_pop_o        (rec_pop),
    .empty_o          (empty_o),
    .pop_i            (pop_i),
    .byte_index_o     (byte_index_o),
    .segment_byte_o   (segment_byte_o),
    .frame_last_o     (frame_last_o),
    .left_lamp_o      (left_lamp_o),
    .right_lamp_o     (right_lamp_o),
    .headlight_lamp_o (headlight_lamp_o)
  );

  a_last_mark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_o |-> (frame_last_o == (byte_index_o == BYTE_IDX_W'(FRAME_BYTES - 1))))
    else $error("frame_last_o does not match byte position");

  a_frame_runs_on: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && pop_i && !frame_last_o) |=>
      (!empty_o && (byte_index_o == $past(byte_index_o) + 5'd1)))
    else $error("frame bytes not delivered back to back");

  a_lamps_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && pop_i && !frame_last_o) |=>
      ($stable(left_lamp_o) && $stable(right_lamp_o) && $stable(headlight_lamp_o)))
    else $error("lamp levels changed within a frame");

endmodule

/* sv/dsfe_front.sv */
module dsfe_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  output logic                full_o,
  input  logic [10:0]         indicator_flags_i,
  input  logic [1:0]          media_source_i,
  input  logic [3:0]          battery_level_i,
  input  logic signed [10:0]  temperature_i,
  input  logic [6:0]          clock_hour_i,
  input  logic [6:0]          clock_minute_i,
  input  logic [2:0]          edit_digit_i,
  input  logic [15:0]         battery_voltage_i,
  input  logic [16:0]         mileage_i,
  input  logic [7:0]          road_speed_i,
  input  logic [2:0]          drive_mode_i,
  input  logic [15:0]         track_number_i,
  input  logic [3:0]          blink_period_i,
  input  logic [3:0]          blink_on_limit_i,
  output dsfe_pkg::dsfe_rec_t rec_o,
  output logic                rec_push_o,
  input  logic                rec_full_i
);
  import dsfe_pkg::*;

  localparam logic [31:0] DIV_RECIP = 32'd26214;
  localparam int          DIV_SHIFT = 18;

  typedef enum logic [2:0] {
    FS_IDLE = 3'b001,
    FS_RUN  = 3'b010,
    FS_PUSH = 3'b100
  } fstate_e;

  fstate_e state_q, state_d;
  logic [STEP_W-1:0] step_q;
  logic [3:0]  blink_count_q;
  logic [4:0]  cnt_q, cnt_nxt;
  logic        on_q;
  logic        accept;

  logic [10:0] flags_q;
  logic [1:0]  media_q;
  logic [3:0]  bat_q;
  logic [2:0]  edit_q;
  logic [2:0]  mode_q;
  logic        neg_q, big_q;
  logic [16:0] mile_q;
  logic [15:0] track_q, volt_q;
  logic [9:0]  tabs_q;
  logic [7:0]  speed_q;
  logic [6:0]  hour_q, min_q;
  logic [16:0] w_q;
  logic [DIG_SLOTS-1:0][3:0] dig_q;

  logic signed [10:0] tsat, tneg;
  logic [9:0]  tabs_c;
  logic [16:0] mile_c;
  logic [6:0]  hour_c, min_c;

  logic [16:0] x, tenq;
  logic [31:0] prod;
  logic [13:0] q0, q;
  logic [4:0]  r0;
  logic [3:0]  r;

  always_comb begin
    if (temperature_i > 11'sd999) begin
      tsat = 11'sd999;
    end else if (temperature_i < -11'sd999) begin
      tsat = -11'sd999;
    end else begin
      tsat = temperature_i;
    end
    tneg   = -tsat;
    tabs_c = tsat[10] ? tneg[9:0] : tsat[9:0];
    mile_c = (mileage_i > 17'd99999) ? 17'd99999 : mileage_i;
    hour_c = (clock_hour_i > 7'd99) ? 7'd99 : clock_hour_i;
    min_c  = (clock_minute_i > 7'd99) ? 7'd99 : clock_minute_i;
  end

  always_comb begin
    unique case (step_q)
      STEP_MILE:  x = mile_q;
      STEP_TRACK: x = 17'(track_q);
      STEP_VOLT:  x = 17'(volt_q);
      STEP_TEMP:  x = 17'(tabs_q);
      STEP_SPEED: x = 17'(speed_q);
      STEP_HOUR:  x = 17'(hour_q);
      STEP_MIN:   x = 17'(min_q);
      default:    x = w_q;
    endcase
    prod = 32'(x) * DIV_RECIP;
    q0   = 14'(prod >> DIV_SHIFT);
    tenq = 17'({q0, 3'b000}) + 17'({q0, 1'b0});
    r0   = 5'(x - tenq);
    if (r0 >= 5'd10) begin
      q = q0 + 14'd1;
      r = 4'(r0 - 5'd10);
    end else begin
      q = q0;
      r = r0[3:0];
    end
  end

  always_comb begin
    if ((blink_period_i != 4'd0) && (cnt_q >= {1'b0, blink_period_i})) begin
      cnt_nxt = cnt_q - {1'b0, blink_period_i};
    end else begin
      cnt_nxt = cnt_q;
    end
  end

  assign full_o = !((state_q == FS_IDLE) || ((state_q == FS_PUSH) && !rec_full_i));
  assign accept = push_i && !full_o;
  assign rec_push_o = (state_q == FS_PUSH) && !rec_full_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      FS_IDLE: begin
        if (push_i) state_d = FS_RUN;
      end
      FS_RUN: begin
        if (step_q == STEP_LAST) state_d = FS_PUSH;
      end
      FS_PUSH: begin
        if (!rec_full_i) state_d = push_i ? FS_RUN : FS_IDLE;
      end
      default: state_d = FS_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= FS_IDLE;
      step_q        <= '0;
      blink_count_q <= '0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        step_q <= '0;
      end else if (state_q == FS_RUN) begin
        step_q <= step_q + 5'd1;
      end
      if ((state_q == FS_RUN) && (step_q == STEP_LAST)) begin
        blink_count_q <= cnt_nxt[3:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      flags_q <= indicator_flags_i;
      media_q <= media_source_i;
      bat_q   <= battery_level_i;
      edit_q  <= edit_digit_i;
      mode_q  <= drive_mode_i;
      neg_q   <= temperature_i[10];
      big_q   <= track_number_i >= 16'd1000;
      mile_q  <= mile_c;
      track_q <= track_number_i;
      volt_q  <= battery_voltage_i;
      tabs_q  <= tabs_c;
      speed_q <= road_speed_i;
      hour_q  <= hour_c;
      min_q   <= min_c;
      cnt_q   <= 5'(blink_count_q) + 5'd1;
    end else if (state_q == FS_RUN) begin
      cnt_q         <= cnt_nxt;
      w_q           <= 17'(q);
      dig_q[step_q] <= r;
      if (step_q == STEP_HOUR) dig_q[DIG_HOUR_TENS] <= q[3:0];
      if (step_q == STEP_MIN) dig_q[DIG_MIN_TENS] <= q[3:0];
      if (step_q == STEP_LAST) on_q <= cnt_nxt[3:0] <= blink_on_limit_i;
    end
  end

  always_comb begin
    rec_o.flags    = flags_q;
    rec_o.media    = media_q;
    rec_o.bat      = bat_q;
    rec_o.temp_neg = neg_q;
    rec_o.edit     = edit_q;
    rec_o.mode     = mode_q;
    rec_o.trk_big  = big_q;
    rec_o.on       = on_q;
    rec_o.dig      = dig_q;
  end

endmodule

/* sv/dsfe_queue.sv */
module dsfe_queue #(
  parameter int DEPTH = dsfe_pkg::QUEUE_DEPTH
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  dsfe_pkg::dsfe_rec_t rec_i,
  output logic                full_o,
  input  logic                pop_i,
  output dsfe_pkg::dsfe_rec_t rec_o,
  output logic                empty_o
);
  import dsfe_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  dsfe_rec_t mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] cnt_q;
  logic do_push, do_pop;

  assign full_o  = cnt_q == CNT_W'(DEPTH);
  assign empty_o = cnt_q == '0;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rec_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= rec_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
      end
      unique case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + CNT_W'(1);
        2'b01:   cnt_q <= cnt_q - CNT_W'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

/* sv/dsfe_back.sv */
module dsfe_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  dsfe_pkg::dsfe_rec_t rec_i,
  input  logic                rec_empty_i,
  output logic                rec_pop_o,
  output logic                empty_o,
  input  logic                pop_i,
  output logic [4:0]          byte_index_o,
  output logic [7:0]          segment_byte_o,
  output logic                frame_last_o,
  output logic                left_lamp_o,
  output logic                right_lamp_o,
  output logic                headlight_lamp_o
);
  import dsfe_pkg::*;

  localparam logic [BYTE_IDX_W-1:0] LAST_IDX = BYTE_IDX_W'(FRAME_BYTES - 1);

  function automatic logic [7:0] seg_time(input logic [3:0] d);
    logic [7:0] v;
    unique case (d)
      4'd0: v = 8'hCF;
      4'd1: v = 8'h06;
      4'd2: v = 8'hAD;
      4'd3: v = 8'h2F;
      4'd4: v = 8'h66;
      4'd5: v = 8'h6B;
      4'd6: v = 8'hEB;
      4'd7: v = 8'h07;
      4'd8: v = 8'hEF;
      4'd9: v = 8'h6F;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

  function automatic logic [7:0] seg_num(input logic [3:0] d);
    logic [7:0] v;
    unique case (d)
      4'd0: v = 8'h3F;
      4'd1: v = 8'h06;
      4'd2: v = 8'h5B;
      4'd3: v = 8'h4F;
      4'd4: v = 8'h66;
      4'd5: v = 8'h6D;
      4'd6: v = 8'h7D;
      4'd7: v = 8'h0E;
      4'd8: v = 8'h7F;
      4'd9: v = 8'h6F;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

  function automatic logic [7:0] seg_temp(input logic [3:0] d);
    logic [7:0] v;
    unique case (d)
      4'd0: v = 8'h3F;
      4'd1: v = 8'h06;
      4'd2: v = 8'h6D;
      4'd3: v = 8'h4F;
      4'd4: v = 8'h56;
      4'd5: v = 8'h5B;
      4'd6: v = 8'h7B;
      4'd7: v = 8'h07;
      4'd8: v = 8'h7F;
      4'd9: v = 8'h5F;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

  function automatic logic [7:0] bat_bars(input logic [3:0] n);
    logic [7:0] v;
    unique case (n)
      4'd1: v = 8'h01;
      4'd2: v = 8'h05;
      4'd3: v = 8'h07;
      4'd4: v = 8'h0F;
      4'd5: v = 8'h8F;
      4'd6: v = 8'hAF;
      4'd7: v = 8'hEF;
      4'd8: v = 8'hFF;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

  function automatic logic [7:0] lo_sh(input logic [7:0] v);
    return {4'h0, v[7:4]};
  endfunction

  function automatic logic [7:0] hi_sh(input logic [7:0] v);
    return {v[3:0], 4'h0};
  endfunction

  logic [BYTE_IDX_W-1:0] k_q;
  logic       ov_q;
  logic [4:0] idx_q;
  logic [7:0] seg_q;
  logic       last_q, left_q, right_q, head_q;
  logic       load;

  logic [7:0] seg_b, clk_seg, mode_bits, media_bits;
  logic       left, right, head, clock_en, colon, blank, bat_icon, play;

  always_comb begin
    left     = rec_i.flags[FLAG_LEFT] && rec_i.on;
    right    = rec_i.flags[FLAG_RIGHT] && rec_i.on;
    head     = rec_i.flags[FLAG_HEAD];
    play     = rec_i.flags[FLAG_PLAY];
    clock_en = rec_i.flags[FLAG_CLOCK];
    colon    = clock_en && (rec_i.flags[FLAG_SETTING] || rec_i.on);
    blank    = clock_en && rec_i.flags[FLAG_SETTING] && !rec_i.on && !rec_i.edit[2]
               && (k_q == BYTE_IDX_W'(rec_i.edit));
    bat_icon = !((rec_i.bat == 4'd0) && !rec_i.on);

    unique case (k_q)
      5'd0:    clk_seg = seg_time(rec_i.dig[DIG_HOUR_TENS]);
      5'd1:    clk_seg = seg_time(rec_i.dig[DIG_HOUR_ONES]);
      5'd2:    clk_seg = seg_time(rec_i.dig[DIG_MIN_TENS]);
      5'd3:    clk_seg = seg_time(rec_i.dig[DIG_MIN_ONES]);
      default: clk_seg = 8'h00;
    endcase
    if (!clock_en) clk_seg = 8'h00;

    unique case (rec_i.mode)
      MODE_ONE:   mode_bits = 8'h80;
      MODE_TWO:   mode_bits = 8'h20;
      MODE_THREE: mode_bits = 8'h40;
      MODE_FOUR:  mode_bits = 8'h10;
      default:    mode_bits = 8'h00;
    endcase

    unique case (rec_i.media)
      MEDIA_FM:  media_bits = 8'h04;
      MEDIA_USB: media_bits = 8'h08;
      MEDIA_BT:  media_bits = 8'h02;
      default:   media_bits = 8'h00;
    endcase

    unique case (k_q)
      5'd0: seg_b = (left ? 8'h10 : 8'h00) | clk_seg;
      5'd1: seg_b = (rec_i.flags[FLAG_CRUISE] ? 8'h10 : 8'h00) | clk_seg;
      5'd2: seg_b = clk_seg;
      5'd3: seg_b = (head ? 8'h10 : 8'h00) | clk_seg;
      5'd4: seg_b = {7'd0, rec_i.flags[FLAG_ECO]}
                    | lo_sh(seg_time(rec_i.dig[DIG_SPD_TENS])) | mode_bits;
      5'd5: seg_b = {7'd0, rec_i.flags[FLAG_REVERSE]}
                    | lo_sh(seg_time(rec_i.dig[DIG_SPD_ONES]))
                    | hi_sh(seg_time(rec_i.dig[DIG_SPD_TENS]));
      5'd6: seg_b = hi_sh(seg_time(rec_i.dig[DIG_SPD_ONES]))
                    | lo_sh(seg_temp(rec_i.dig[DIG_TEMP_TENS]))
                    | (rec_i.temp_neg ? 8'h08 : 8'h00);
      5'd7: seg_b = lo_sh(seg_temp(rec_i.dig[DIG_TEMP_ONES]))
                    | hi_sh(seg_temp(rec_i.dig[DIG_TEMP_TENS])) | 8'h08;
      5'd8: seg_b = hi_sh(seg_temp(rec_i.dig[DIG_TEMP_ONES]))
                    | (seg_num(rec_i.dig[DIG_MILE]) & 8'h0F);
      5'd9: seg_b = (seg_num(rec_i.dig[DIG_MILE]) & 8'hF0)
                    | (seg_num(rec_i.dig[DIG_MILE + 1]) & 8'h0F) | 8'h80;
      5'd10: seg_b = (right ? 8'h80 : 8'h00)
                     | (seg_num(rec_i.dig[DIG_MILE + 1]) & 8'hF0)
                     | (seg_num(rec_i.dig[DIG_MILE + 2]) & 8'h0F);
      5'd11: seg_b = (seg_num(rec_i.dig[DIG_MILE + 2]) & 8'hF0)
                     | (seg_num(rec_i.dig[DIG_MILE + 3]) & 8'h0F) | 8'h80;
      5'd12: seg_b = (rec_i.flags[FLAG_BRAKE] ? 8'h80 : 8'h00)
                     | (seg_num(rec_i.dig[DIG_MILE + 3]) & 8'hF0)
                     | (seg_num(rec_i.dig[DIG_MILE + 4]) & 8'h0F);
      5'd13: seg_b = (bat_icon ? 8'h80 : 8'h00)
                     | (seg_num(rec_i.dig[DIG_MILE + 4]) & 8'hF0)
                     | (seg_num(rec_i.dig[DIG_TRACK]) & 8'h0F);
      5'd14: seg_b = (seg_num(rec_i.dig[DIG_TRACK]) & 8'hF0)
                     | (seg_num(rec_i.dig[DIG_TRACK + 1]) & 8'h0F)
                     | ((rec_i.media == MEDIA_FM) ? 8'h80 : 8'h00);
      5'd15: seg_b = (play ? 8'h80 : 8'h00)
                     | (seg_num(rec_i.dig[DIG_TRACK + 1]) & 8'hF0)
                     | (seg_num(rec_i.dig[DIG_TRACK + 2]) & 8'h0F);
      5'd16: seg_b = media_bits | (play ? 8'h00 : 8'h80)
                     | (seg_num(rec_i.dig[DIG_TRACK + 2]) & 8'hF0)
                     | (rec_i.trk_big ? 8'h01 : 8'h00);
      5'd17: seg_b = lo_sh(seg_num(rec_i.dig[DIG_VOLT_TENS]))
                     | hi_sh(seg_num(rec_i.dig[DIG_VOLT_TENS])) | 8'h08;
      5'd18: seg_b = (rec_i.flags[FLAG_CHARGE] ? 8'h08 : 8'h00)
                     | lo_sh(seg_num(rec_i.dig[DIG_VOLT_HUND]))
                     | hi_sh(seg_num(rec_i.dig[DIG_VOLT_HUND]));
      5'd19: seg_b = bat_bars(rec_i.bat);
      default: seg_b = 8'h00;
    endcase
    if (blank) seg_b = seg_b & 8'h10;
    if ((k_q == 5'd2) && colon) seg_b = seg_b | 8'h10;
  end

  assign load      = !rec_empty_i && (!ov_q || pop_i);
  assign rec_pop_o = load && (k_q == LAST_IDX);
  assign empty_o   = !ov_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
      k_q  <= '0;
    end else begin
      if (load) begin
        ov_q <= 1'b1;
        k_q  <= (k_q == LAST_IDX) ? '0 : k_q + BYTE_IDX_W'(1);
      end else if (pop_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      idx_q   <= k_q;
      seg_q   <= seg_b;
      last_q  <= k_q == LAST_IDX;
      left_q  <= left;
      right_q <= right;
      head_q  <= head;
    end
  end

  assign byte_index_o     = idx_q;
  assign segment_byte_o   = seg_q;
  assign frame_last_o     = last_q;
  assign left_lamp_o      = left_q;
  assign right_lamp_o     = right_q;
  assign headlight_lamp_o = head_q;

endmodule

/* tb/lcd_frame_checker.sv */
`timescale 1ns / 1ps

module lcd_frame_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           push_i,
  input  logic                           full_i,
  input  logic [10:0]                    indicator_flags_i,
  input  logic [1:0]                     media_source_i,
  input  logic [3:0]                     battery_level_i,
  input  logic signed [10:0]             temperature_i,
  input  logic [6:0]                     clock_hour_i,
  input  logic [6:0]                     clock_minute_i,
  input  logic [2:0]                     edit_digit_i,
  input  logic [15:0]                    battery_voltage_i,
  input  logic [16:0]                    mileage_i,
  input  logic [7:0]                     road_speed_i,
  input  logic [2:0]                     drive_mode_i,
  input  logic [15:0]                    track_number_i,
  input  logic                           empty_i,
  input  logic                           pop_i,
  input  logic [4:0]                     byte_index_i,
  input  logic [7:0]                     segment_byte_i,
  input  logic                           frame_last_i,
  input  logic                           left_lamp_i,
  input  logic                           right_lamp_i,
  input  logic                           headlight_lamp_i,
  input  logic                           cfg_valid_i,
  input  logic                           cfg_ready_i,
  input  logic [dsfe_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [3:0]                     cfg_data_i,
  output int                             mismatch_count_o,
  output int                             pending_o
);
  import dsfe_pkg::*;

  localparam logic [0:9][7:0] TIME_DIGITS =
    {8'hCF, 8'h06, 8'hAD, 8'h2F, 8'h66, 8'h6B, 8'hEB, 8'h07, 8'hEF, 8'h6F};
  localparam logic [0:9][7:0] NUM_DIGITS =
    {8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h0E, 8'h7F, 8'h6F};
  localparam logic [0:9][7:0] TEMP_DIGITS =
    {8'h3F, 8'h06, 8'h6D, 8'h4F, 8'h56, 8'h5B, 8'h7B, 8'h07, 8'h7F, 8'h5F};
  localparam logic [0:8][7:0] BAT_BARS =
    {8'h00, 8'h01, 8'h05, 8'h07, 8'h0F, 8'h8F, 8'hAF, 8'hEF, 8'hFF};

  typedef logic [FRAME_BYTES-1:0][7:0] lcd_frame_t;

  typedef struct packed {
    logic [10:0] flags;
    logic [1:0]  media;
    logic [3:0]  bat;
    logic [10:0] temp;
    logic [6:0]  hour;
    logic [6:0]  minute;
    logic [2:0]  edit;
    logic [15:0] volt;
    logic [16:0] mile;
    logic [7:0]  speed;
    logic [2:0]  mode;
    logic [15:0] track;
  } snapshot_t;

  typedef struct packed {
    logic [4:0] idx;
    logic [7:0] seg;
    logic       last;
    logic       left_on;
    logic       right_on;
    logic       head_on;
  } lcd_beat_t;

  lcd_beat_t  expected_bytes[$];
  logic [3:0] blink_period;
  logic [3:0] blink_on_limit;
  logic [3:0] blink_count;
  int         errs;

  function automatic lcd_frame_t encode_frame(input snapshot_t s, input logic on_phase);
    lcd_frame_t f;
    logic [7:0] p;
    int t;
    int deg;
    int hr;
    int mn;
    int mi;
    int tr;
    f = '0;
    if (s.flags[FLAG_LEFT] && on_phase) f[0] |= 8'h10;
    if (s.flags[FLAG_RIGHT] && on_phase) f[10] |= 8'h80;
    if (s.flags[FLAG_HEAD]) f[3] |= 8'h10;
    if (s.flags[FLAG_CRUISE]) f[1] |= 8'h10;
    if (s.flags[FLAG_ECO]) f[4] |= 8'h01;
    if (s.flags[FLAG_REVERSE]) f[5] |= 8'h01;
    if (s.flags[FLAG_BRAKE]) f[12] |= 8'h80;
    if (s.flags[FLAG_CHARGE]) f[18] |= 8'h08;
    case (s.media)
      MEDIA_FM:  f[16] |= 8'h04;
      MEDIA_USB: f[16] |= 8'h08;
      MEDIA_BT:  f[16] |= 8'h02;
      default: ;
    endcase
    if (s.flags[FLAG_PLAY]) f[15] |= 8'h80;
    else f[16] |= 8'h80;

    f[13] |= 8'h80;
    if (s.bat == 4'd0) begin
      if (!on_phase) f[13] &= 8'h7F;
    end else if (s.bat <= 4'd8) begin
      f[19] |= BAT_BARS[s.bat];
    end

    t = $signed(s.temp);
    if (t > 999) t = 999;
    if (t < -999) t = -999;
    deg = (t < 0 ? -t : t) / 10;
    p = TEMP_DIGITS[deg % 10];
    f[7] |= p >> 4;
    f[8] |= {p[3:0], 4'h0};
    p = TEMP_DIGITS[(deg / 10) % 10];
    f[6] |= p >> 4;
    f[7] |= {p[3:0], 4'h0};
    f[7] |= 8'h08;
    if (t < 0) f[6] |= 8'h08;

    if (s.flags[FLAG_CLOCK]) begin
      hr = (s.hour > 7'd99) ? 99 : int'(s.hour);
      mn = (s.minute > 7'd99) ? 99 : int'(s.minute);
      f[0] |= TIME_DIGITS[hr / 10];
      f[1] |= TIME_DIGITS[hr % 10];
      f[2] |= TIME_DIGITS[mn / 10];
      f[3] |= TIME_DIGITS[mn % 10];
      if (s.flags[FLAG_SETTING]) begin
        if (!on_phase && s.edit <= 3'd3) f[s.edit] &= 8'h10;
        f[2] |= 8'h10;
      end else if (on_phase) begin
        f[2] |= 8'h10;
      end
    end

    // both nibble shifts land in the same byte
    p = NUM_DIGITS[(s.volt / 10) % 10];
    f[17] |= (p >> 4) | {p[3:0], 4'h0};
    p = NUM_DIGITS[(s.volt / 100) % 10];
    f[18] |= (p >> 4) | {p[3:0], 4'h0};
    f[17] |= 8'h08;

    mi = (s.mile > 17'd99999) ? 99999 : int'(s.mile);
    for (int k = 0; k < 5; k++) begin
      p = NUM_DIGITS[mi % 10];
      mi = mi / 10;
      f[8 + k] |= p & 8'h0F;
      f[9 + k] |= p & 8'hF0;
    end
    f[9] |= 8'h80;

    p = TIME_DIGITS[s.speed % 10];
    f[5] |= p >> 4;
    f[6] |= {p[3:0], 4'h0};
    p = TIME_DIGITS[(s.speed / 10) % 10];
    f[4] |= p >> 4;
    f[5] |= {p[3:0], 4'h0};
    f[11] |= 8'h80;

    case (s.mode)
      MODE_ONE:   f[4] |= 8'h80;
      MODE_TWO:   f[4] |= 8'h20;
      MODE_THREE: f[4] |= 8'h40;
      MODE_FOUR:  f[4] |= 8'h10;
      default:    f[4] &= 8'h0F;
    endcase

    tr = s.track;
    for (int k = 0; k < 3; k++) begin
      p = NUM_DIGITS[tr % 10];
      tr = tr / 10;
      f[13 + k] |= p & 8'h0F;
      f[14 + k] |= p & 8'hF0;
    end
    if (s.track >= 16'd1000) f[16] |= 8'h01;
    if (s.media == MEDIA_FM) f[14] |= 8'h80;
    return f;
  endfunction

  task automatic compare_field(input string what, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s expected 0x%0h actual 0x%0h", $time, what, want, got);
      errs++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    snapshot_t  snap;
    lcd_frame_t frame;
    lcd_beat_t  beat;
    lcd_beat_t  want;
    logic       on_phase;
    if (!rst_ni) begin
      expected_bytes.delete();
      blink_period   = BLINK_PERIOD_RST;
      blink_on_limit = BLINK_ON_RST;
      blink_count    = 4'd0;
      errs           = 0;
    end else begin
      if (pop_i && !empty_i) begin
        if (expected_bytes.size() == 0) begin
          $display("%0t: unexpected frame beat, expected none actual index %0d byte 0x%0h",
                   $time, byte_index_i, segment_byte_i);
          errs++;
        end else begin
          want = expected_bytes.pop_front();
          compare_field("byte_index", want.idx, byte_index_i);
          compare_field("segment_byte", want.seg, segment_byte_i);
          compare_field("frame_last", want.last, frame_last_i);
          compare_field("left_lamp", want.left_on, left_lamp_i);
          compare_field("right_lamp", want.right_on, right_lamp_i);
          compare_field("headlight_lamp", want.head_on, headlight_lamp_i);
        end
      end

      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_BLINK_PERIOD: blink_period = cfg_data_i;
          CFG_BLINK_ON:     blink_on_limit = cfg_data_i;
          default: ;
        endcase
      end

      if (push_i && !full_i) begin
        snap = '{indicator_flags_i, media_source_i, battery_level_i, temperature_i,
                 clock_hour_i, clock_minute_i, edit_digit_i, battery_voltage_i,
                 mileage_i, road_speed_i, drive_mode_i, track_number_i};
        if (blink_period == 4'd0) blink_count = blink_count + 4'd1;
        else blink_count = 4'((blink_count + 1) % blink_period);
        on_phase = (blink_count <= blink_on_limit);
        frame = encode_frame(snap, on_phase);
        for (int k = 0; k < FRAME_BYTES; k++) begin
          beat.idx      = 5'(k);
          beat.seg      = frame[k];
          beat.last     = (k == FRAME_BYTES - 1);
          beat.left_on  = snap.flags[FLAG_LEFT] && on_phase;
          beat.right_on = snap.flags[FLAG_RIGHT] && on_phase;
          beat.head_on  = snap.flags[FLAG_HEAD];
          expected_bytes.push_back(beat);
        end
      end
    end
    mismatch_count_o <= errs;
    pending_o        <= expected_bytes.size();
  end

endmodule

/* tb/dashboard_segment_frame_encoder_top_tb.sv */
`timescale 1ns / 1ps

module dashboard_segment_frame_encoder_top_tb;
  import dsfe_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  localparam int IDLE_PCT = 27;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 push_i;
  logic                 full_o;
  logic [10:0]          indicator_flags_i;
  logic [1:0]           media_source_i;
  logic [3:0]           battery_level_i;
  logic signed [10:0]   temperature_i;
  logic [6:0]           clock_hour_i;
  logic [6:0]           clock_minute_i;
  logic [2:0]           edit_digit_i;
  logic [15:0]          battery_voltage_i;
  logic [16:0]          mileage_i;
  logic [7:0]           road_speed_i;
  logic [2:0]           drive_mode_i;
  logic [15:0]          track_number_i;
  logic                 empty_o;
  logic                 pop_i;
  logic [4:0]           byte_index_o;
  logic [7:0]           segment_byte_o;
  logic                 frame_last_o;
  logic                 left_lamp_o;
  logic                 right_lamp_o;
  logic                 headlight_lamp_o;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [3:0]           cfg_data_i;
  logic                 steady_run;
  int                   mismatch_count;
  int                   pending_bytes;

  always #10 clk_i = ~clk_i;

  dashboard_segment_frame_encoder_top dut (.*);

  lcd_frame_checker u_lcd_frame_checker (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .push_i            (push_i),
    .full_i            (full_o),
    .indicator_flags_i (indicator_flags_i),
    .media_source_i    (media_source_i),
    .battery_level_i   (battery_level_i),
    .temperature_i     (temperature_i),
    .clock_hour_i      (clock_hour_i),
    .clock_minute_i    (clock_minute_i),
    .edit_digit_i      (edit_digit_i),
    .battery_voltage_i (battery_voltage_i),
    .mileage_i         (mileage_i),
    .road_speed_i      (road_speed_i),
    .drive_mode_i      (drive_mode_i),
    .track_number_i    (track_number_i),
    .empty_i           (empty_o),
    .pop_i             (pop_i),
    .byte_index_i      (byte_index_o),
    .segment_byte_i    (segment_byte_o),
    .frame_last_i      (frame_last_o),
    .left_lamp_i       (left_lamp_o),
    .right_lamp_i      (right_lamp_o),
    .headlight_lamp_i  (headlight_lamp_o),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_i       (cfg_ready_o),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .mismatch_count_o  (mismatch_count),
    .pending_o         (pending_bytes)
  );

  always @(posedge clk_i) begin
    pop_i <= rst_ni && (steady_run || $urandom_range(0, 99) >= IDLE_PCT);
  end

  task automatic send_snapshot(input logic [10:0] flags, input logic [1:0] media,
                               input logic [3:0] bat, input logic [10:0] temp,
                               input logic [6:0] hour, input logic [6:0] minute,
                               input logic [2:0] edit, input logic [15:0] volt,
                               input logic [16:0] mile, input logic [7:0] speed,
                               input logic [2:0] mode, input logic [15:0] track);
    while (!steady_run && $urandom_range(0, 99) < IDLE_PCT) begin
      push_i <= 1'b0;
      @(posedge clk_i);
    end
    push_i            <= 1'b1;
    indicator_flags_i <= flags;
    media_source_i    <= media;
    battery_level_i   <= bat;
    temperature_i     <= temp;
    clock_hour_i      <= hour;
    clock_minute_i    <= minute;
    edit_digit_i      <= edit;
    battery_voltage_i <= volt;
    mileage_i         <= mile;
    road_speed_i      <= speed;
    drive_mode_i      <= mode;
    track_number_i    <= track;
    @(posedge clk_i);
    while (full_o) @(posedge clk_i);
  endtask

  task automatic send_random_snapshots(input int count);
    logic [16:0] mile;
    repeat (count) begin
      mile = ($urandom_range(0, 3) == 0) ? 17'($urandom_range(99990, 131071))
                                         : 17'($urandom_range(0, 99999));
      send_snapshot(11'($urandom), 2'($urandom), 4'($urandom), 11'($urandom),
                    7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)),
                    3'($urandom), 16'($urandom), mile, 8'($urandom),
                    3'($urandom), 16'($urandom));
    end
  endtask

  task automatic wait_idle();
    push_i <= 1'b0;
    @(posedge clk_i);
    while (pending_bytes != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [3:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
  endtask

  task automatic set_blink(input logic [3:0] period, input logic [3:0] on_limit);
    wait_idle();
    write_reg(CFG_BLINK_PERIOD, period);
    write_reg(CFG_BLINK_ON, on_limit);
    // spare index: must be dropped
    write_reg(CFG_SPARE, ~period);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    rst_ni            = 1'b0;
    push_i            = 1'b0;
    steady_run        = 1'b0;
    indicator_flags_i = '0;
    media_source_i    = '0;
    battery_level_i   = '0;
    temperature_i     = '0;
    clock_hour_i      = '0;
    clock_minute_i    = '0;
    edit_digit_i      = '0;
    battery_voltage_i = '0;
    mileage_i         = '0;
    road_speed_i      = '0;
    drive_mode_i      = '0;
    track_number_i    = '0;
    cfg_valid_i       = 1'b0;
    cfg_index_i       = '0;
    cfg_data_i        = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_snapshot(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    send_snapshot(2047, 3, 8, 999, 99, 99, 3, 65535, 99999, 255, 4, 65535);
    send_snapshot(2047, 3, 15, 1023, 127, 127, 7, 65535, 131071, 255, 7, 65535);
    send_snapshot(11'h600, 0, 9, -1024, 100, 100, 4, 999, 100000, 99, 5, 999);
    send_snapshot(11'h601, 1, 0, -5, 23, 59, 1, 120, 12345, 7, 6, 1000);
    for (int i = 0; i < 16; i++) begin
      send_snapshot((i < 12) ? 11'h603 : 11'h207, 2'(i % 4), 4'(i), 11'(-(i * 37)),
                    7'(i * 7), 7'(i * 9), 3'(i % 8), 16'(i * 1234), 17'(i * 6666),
                    8'(i * 17), 3'(i % 8), 16'(i * 999));
    end

    set_blink(3, 0);
    send_random_snapshots(64);
    set_blink(0, 15);
    steady_run <= 1'b1;
    send_random_snapshots(64);
    steady_run <= 1'b0;
    set_blink(2, 1);
    send_random_snapshots(64);
    set_blink(15, 7);
    send_random_snapshots(64);
    set_blink(1, 0);
    send_random_snapshots(64);

    wait_idle();
    repeat (25) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("dashboard_segment_frame_encoder_top: match");
    end else begin
      $display("dashboard_segment_frame_encoder_top: mismatch");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("dashboard_segment_frame_encoder_top: mismatch");
    $finish;
  end

endmodule
